>>> hw/rtl/tsd_pkg.sv
// Shared types and constants for the Taylor-series sine block.
// Used by taylor_sine_degrees, tsd_div and tsd_checker; depends on nothing.
package tsd_pkg;

  // Field widths
  localparam int ANGLE_W = 16;
  localparam int ORDER_W = 5;
  localparam int OUT_W   = 26;

  // Series configuration
  localparam int ORDER_LIMIT = 31;
  localparam int ORDER_RESET = 7;
  localparam int FRAC_BITS   = 16;
  localparam int TERM_FRAC   = 40;
  localparam int ROUND_SHIFT = TERM_FRAC - FRAC_BITS;

  // Angle conversion: deg -> milliradians with 3.14 for pi
  localparam int FULL_TURN  = 360;
  localparam int MRAD_NUM   = 3140;
  localparam int MRAD_DEN   = 180;
  localparam int MRAD_SCALE = 1000;

  // Datapath widths
  localparam int M_W    = 13;  // milliradians, at most 6280
  localparam int TERM_W = 48;  // one series term, Q40, below 2^47
  localparam int SUM_W  = 52;  // positive and negative partial sums
  localparam int Q_W    = SUM_W + 1 - ROUND_SHIFT;
  localparam int PROD_W = TERM_W + M_W;

  // Shared divider: 64-bit dividend, divisor below 2^15, 8 quotient bits a cycle
  localparam int DIV_W        = 64;
  localparam int DVS_W        = 15;
  localparam int DIV_STEP     = 8;
  localparam int DIV_CYCLES   = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W    = $clog2(DIV_CYCLES + 1);

  // Output limits
  localparam int OUT_MAX     = 2**(OUT_W-1) - 1;
  localparam int OUT_MIN_MAG = 2**(OUT_W-1);
  localparam logic signed [OUT_W-1:0] OUT_POS_LIM = OUT_W'(OUT_MAX);
  localparam logic signed [OUT_W-1:0] OUT_NEG_LIM = OUT_W'(-OUT_MIN_MAG);

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_MOD_W,
    S_MMUL,
    S_MDIV,
    S_MDIV_W,
    S_T1,
    S_T1_W,
    S_ACC,
    S_TMUL,
    S_TDIV,
    S_TDIV_W,
    S_ROUND,
    S_OUT
  } tsd_state_e;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> hw/rtl/tsd_div.sv
// Shared unsigned long divider, restoring, eight quotient bits per cycle.
// Depends on tsd_pkg for widths and the request/response structs.
module tsd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsd_pkg::div_req_t req_i,
  output tsd_pkg::div_rsp_t rsp_o
);
  import tsd_pkg::*;

  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic                 busy;
  logic [DIV_W-1:0]     step_dvd;
  logic [DVS_W-1:0]     step_rem;

  assign busy = (cnt_q != '0);

  // Retire eight quotient bits: shift in dividend bits, subtract where it fits
  always_comb begin
    logic [DVS_W:0] part;
    part     = '0;
    step_rem = rem_q;
    step_dvd = dvd_q;
    for (int i = 0; i < DIV_STEP; i++) begin
      part     = {step_rem, step_dvd[DIV_W-1]};
      step_dvd = {step_dvd[DIV_W-2:0], 1'b0};
      if (part >= {1'b0, dvs_q}) begin
        step_rem    = DVS_W'(part - {1'b0, dvs_q});
        step_dvd[0] = 1'b1;
      end else begin
        step_rem = part[DVS_W-1:0];
      end
    end
  end

  // Load on start, iterate while busy
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (busy) begin
      dvd_d  = step_dvd;
      rem_d  = step_rem;
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
    end else if (req_i.start) begin
      dvd_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = DIV_CNT_W'(DIV_CYCLES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> hw/rtl/taylor_sine_degrees.sv
// Sine of an angle in whole degrees by its Taylor series, signed Q16 result.
// Top level: sequencer, shared 48x13 multiplier, tsd_div; depends on tsd_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / angle_degrees_i): one angle per
//   transaction. in_stall_o is high while an angle is being worked on.
//   Output channel (out_valid_o / out_stall_i / sine_value_o / saturated_o):
//   one result per transaction, held in an output register.
//   Configuration: cfg_we_i writes cfg_max_order_i into the order register
//   (reset value 7); write it only while the block is idle.
// Sequence: each divide runs on the shared divider at 8 quotient bits a cycle,
//   each multiply on the shared multiplier. After acceptance the block reduces
//   the angle modulo 360 when it exceeds 360, converts it to milliradians,
//   forms the first term, then builds each further odd-exponent term up to the
//   order by multiplies and divides, and rounds the sums into the result.
// Throughput: one angle at a time; the next one is accepted the cycle after
//   the result enters the output register, even if it is still waiting.
// Reset: asynchronous, clears the sequencer, the output valid and sets the
//   order back to 7. A stalled receiver holds the result and, once a new
//   result is ready, holds the sequencer in its output state.
module taylor_sine_degrees (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic        [tsd_pkg::ORDER_W-1:0] cfg_max_order_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic        [tsd_pkg::ANGLE_W-1:0] angle_degrees_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tsd_pkg::OUT_W-1:0]   sine_value_o,
  output logic                              saturated_o
);
  import tsd_pkg::*;

  tsd_state_e state_q, state_d;

  logic [ORDER_W-1:0]  order_q;
  logic [ORDER_W-1:0]  lim_q, lim_d;
  logic [ORDER_W-1:0]  n_q, n_d;
  logic [ORDER_W-1:0]  k_q, k_d;
  logic [ANGLE_W-1:0]  deg_q, deg_d;
  logic [M_W-1:0]      m_q, m_d;
  logic [TERM_W-1:0]   t_q, t_d;
  logic [DIV_W-1:0]    prod_q, prod_d;
  logic [SUM_W-1:0]    pos_q, pos_d;
  logic [SUM_W-1:0]    neg_q, neg_d;
  logic                to_neg_q, to_neg_d;
  logic [SUM_W-1:0]    mag_q, mag_d;
  logic                negative_q, negative_d;
  logic                out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] sine_q, sine_d;
  logic                sat_q, sat_d;

  logic                in_acc;
  logic                out_take;
  logic                out_load;
  logic                last_term;
  logic [ORDER_W:0]    n_next;
  logic [TERM_W-1:0]   mul_a;
  logic [M_W-1:0]      mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [DVS_W-1:0]    term_dvs;
  logic [SUM_W:0]      rnd;
  logic [Q_W-1:0]      q_raw;
  logic [Q_W-1:0]      q_clip;
  logic                q_sat;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  tsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Handshakes
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Series loop bookkeeping
  assign n_next    = {1'b0, n_q} + (ORDER_W+1)'(2);
  assign last_term = (n_next > {1'b0, lim_q});
  assign term_dvs  = DVS_W'(k_q * MRAD_SCALE);

  // Shared multiplier: degrees times 3140, or term times milliradians
  assign mul_a = (state_q == S_TMUL) ? t_q : TERM_W'(deg_q);
  assign mul_b = (state_q == S_TMUL) ? m_q : M_W'(MRAD_NUM);
  assign mul_p = mul_a * mul_b;

  // Round Q40 magnitude to nearest, ties away from zero, then clip
  always_comb begin
    rnd    = {1'b0, mag_q} + (SUM_W+1)'(2**(ROUND_SHIFT-1));
    q_raw  = rnd[SUM_W:ROUND_SHIFT];
    q_sat  = negative_q ? (q_raw > Q_W'(OUT_MIN_MAG)) : (q_raw > Q_W'(OUT_MAX));
    q_clip = q_raw;
    if (q_sat) begin
      q_clip = negative_q ? Q_W'(OUT_MIN_MAG) : Q_W'(OUT_MAX);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (angle_degrees_i > ANGLE_W'(FULL_TURN)) ? S_MOD : S_MMUL;
        end
      end
      S_MOD:    state_d = S_MOD_W;
      S_MOD_W:  if (div_rsp.done) state_d = S_MMUL;
      S_MMUL:   state_d = S_MDIV;
      S_MDIV:   state_d = S_MDIV_W;
      S_MDIV_W: if (div_rsp.done) state_d = S_T1;
      S_T1:     state_d = S_T1_W;
      S_T1_W: begin
        if (div_rsp.done) begin
          state_d = (lim_q == '0) ? S_ROUND : S_ACC;
        end
      end
      S_ACC:    state_d = last_term ? S_ROUND : S_TMUL;
      S_TMUL:   state_d = S_TDIV;
      S_TDIV:   state_d = S_TDIV_W;
      S_TDIV_W: begin
        if (div_rsp.done) begin
          state_d = (k_q == n_q) ? S_ACC : S_TMUL;
        end
      end
      S_ROUND:  state_d = S_OUT;
      S_OUT:    if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath control and divider requests
  always_comb begin
    lim_d      = lim_q;
    n_d        = n_q;
    k_d        = k_q;
    deg_d      = deg_q;
    m_d        = m_q;
    t_d        = t_q;
    prod_d     = prod_q;
    pos_d      = pos_q;
    neg_d      = neg_q;
    to_neg_d   = to_neg_q;
    mag_d      = mag_q;
    negative_d = negative_q;
    div_req    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          deg_d    = angle_degrees_i;
          lim_d    = (order_q > ORDER_W'(ORDER_LIMIT)) ? ORDER_W'(ORDER_LIMIT) : order_q;
          n_d      = ORDER_W'(1);
          k_d      = ORDER_W'(1);
          pos_d    = '0;
          neg_d    = '0;
          to_neg_d = 1'b0;
        end
      end
      S_MOD: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(deg_q);
        div_req.divisor  = DVS_W'(FULL_TURN);
      end
      S_MOD_W: begin
        if (div_rsp.done) deg_d = ANGLE_W'(div_rsp.remainder);
      end
      S_MMUL: begin
        prod_d = DIV_W'(mul_p);
      end
      S_MDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = DVS_W'(MRAD_DEN);
      end
      S_MDIV_W: begin
        if (div_rsp.done) m_d = M_W'(div_rsp.quotient);
      end
      S_T1: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(m_q) << TERM_FRAC;
        div_req.divisor  = DVS_W'(MRAD_SCALE);
      end
      S_T1_W: begin
        if (div_rsp.done) t_d = TERM_W'(div_rsp.quotient);
      end
      S_ACC: begin
        // Add the term to the alternating sums and set up the next term
        if (to_neg_q) begin
          neg_d = neg_q + SUM_W'(t_q);
        end else begin
          pos_d = pos_q + SUM_W'(t_q);
        end
        to_neg_d = !to_neg_q;
        if (!last_term) begin
          n_d = ORDER_W'(n_next);
          k_d = n_q + ORDER_W'(1);
        end
      end
      S_TMUL: begin
        prod_d = DIV_W'(mul_p);
      end
      S_TDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = term_dvs;
      end
      S_TDIV_W: begin
        if (div_rsp.done) begin
          t_d = TERM_W'(div_rsp.quotient);
          if (k_q != n_q) k_d = k_q + ORDER_W'(1);
        end
      end
      S_ROUND: begin
        negative_d = (neg_q > pos_q);
        mag_d      = (neg_q > pos_q) ? (neg_q - pos_q) : (pos_q - neg_q);
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: load a finished result, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    sine_d      = sine_q;
    sat_d       = sat_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      sine_d      = negative_q ? OUT_W'(Q_W'(0) - q_clip) : OUT_W'(q_clip);
      sat_d       = q_sat;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      order_q     <= ORDER_W'(ORDER_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) order_q <= cfg_max_order_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q      <= lim_d;
    n_q        <= n_d;
    k_q        <= k_d;
    deg_q      <= deg_d;
    m_q        <= m_d;
    t_q        <= t_d;
    prod_q     <= prod_d;
    pos_q      <= pos_d;
    neg_q      <= neg_d;
    to_neg_q   <= to_neg_d;
    mag_q      <= mag_d;
    negative_q <= negative_d;
    sine_q     <= sine_d;
    sat_q      <= sat_d;
  end

  assign out_valid_o  = out_valid_q;
  assign sine_value_o = sine_q;
  assign saturated_o  = sat_q;

endmodule

>>> hw/rtl/tsd_checker.sv
// Port-level checks for taylor_sine_degrees, attached by bind.
// Depends on tsd_pkg for the output limits.
module tsd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [tsd_pkg::OUT_W-1:0]   sine_value_o,
  input logic                              saturated_o
);
  import tsd_pkg::*;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sine_value_o) && $stable(saturated_o))
    else $error("stalled result changed or dropped");

  // Go busy right after taking an angle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block ready again right after accepting an angle");

  // A result never shows up the cycle after an angle is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after acceptance");

  // A clipped result sits at one of the field limits
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> sine_value_o == OUT_POS_LIM || sine_value_o == OUT_NEG_LIM)
    else $error("saturated flag set on a value inside the range");

endmodule

bind taylor_sine_degrees tsd_checker u_tsd_checker (.*);
